### rtl/rpn_pkg.sv
package rpn_pkg;

  localparam int DATA_W      = 48;
  localparam int FRAC_BITS   = 24;
  localparam int STACK_DEPTH = 16;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int HALF_W      = DATA_W / 2;
  localparam int PROD_W      = 2 * DATA_W;
  localparam int QUO_W       = DATA_W + FRAC_BITS;
  localparam int TOK_LEN_W   = 2;
  localparam int STATUS_W    = 3;

  typedef logic signed [DATA_W-1:0] val_t;
  typedef logic [DATA_W-1:0]        mag_t;
  typedef logic [STATUS_W-1:0]      status_t;

  localparam val_t VAL_MAX = val_t'({1'b0, {(DATA_W-1){1'b1}}});
  localparam val_t VAL_MIN = val_t'({1'b1, {(DATA_W-1){1'b0}}});

  localparam status_t ST_OK       = 3'd0;
  localparam status_t ST_FEW      = 3'd1;
  localparam status_t ST_DIV0     = 3'd2;
  localparam status_t ST_INVALID  = 3'd3;
  localparam status_t ST_DEPTH    = 3'd4;
  localparam status_t ST_OVERFLOW = 3'd5;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_MUL,
    S_DIV,
    S_FIN
  } state_t;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV
  } op_t;

  function automatic mag_t fx_mag(input val_t v);
    mag_t m;
    m = $unsigned(v);
    if (v[DATA_W-1]) begin
      m = mag_t'(0) - m;
    end
    return m;
  endfunction

  function automatic val_t fx_sat(input logic ovf, input logic neg, input mag_t mag);
    val_t r;
    if (ovf) begin
      r = neg ? VAL_MIN : VAL_MAX;
    end else if (neg) begin
      r = val_t'(mag_t'(0) - mag);
    end else begin
      r = val_t'(mag);
    end
    return r;
  endfunction

endpackage

### rtl/rpn_stack_ram.sv
module rpn_stack_ram
  import rpn_pkg::*;
(
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  val_t              wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output val_t              rd_data
);

  val_t mem [STACK_DEPTH];
  val_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/rpn_mul.sv
module rpn_mul
  import rpn_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  val_t a,
  input  val_t b,
  output logic done,
  output val_t result
);

  localparam logic [2:0] PH_LAST = 3'd5;

  logic                busy_r;
  logic [2:0]          phase_r;
  mag_t                ma_r, mb_r;
  logic                neg_r;
  logic [PROD_W-1:0]   pp_r, acc_r;
  logic [PROD_W-1:0]   pp_sh;
  logic [DATA_W-1:0]   pp;
  logic [HALF_W-1:0]   a0, a1, b0, b1;
  logic                ovf;

  assign a0 = ma_r[HALF_W-1:0];
  assign a1 = ma_r[DATA_W-1:HALF_W];
  assign b0 = mb_r[HALF_W-1:0];
  assign b1 = mb_r[DATA_W-1:HALF_W];

  always_comb begin
    pp    = '0;
    pp_sh = '0;
    case (phase_r)
      3'd0: begin
        pp    = a0 * b0;
        pp_sh = PROD_W'(pp);
      end
      3'd1: begin
        pp    = a0 * b1;
        pp_sh = PROD_W'(pp) << HALF_W;
      end
      3'd2: begin
        pp    = a1 * b0;
        pp_sh = PROD_W'(pp) << HALF_W;
      end
      3'd3: begin
        pp    = a1 * b1;
        pp_sh = PROD_W'(pp) << DATA_W;
      end
      default: begin
        pp    = '0;
        pp_sh = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (busy_r && phase_r == PH_LAST) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      phase_r <= '0;
      acc_r   <= '0;
      ma_r    <= fx_mag(a);
      mb_r    <= fx_mag(b);
      neg_r   <= a[DATA_W-1] ^ b[DATA_W-1];
    end else if (busy_r) begin
      phase_r <= phase_r + 3'd1;
      pp_r    <= pp_sh;
      if (phase_r != 3'd0 && phase_r != PH_LAST) begin
        acc_r <= acc_r + pp_r;
      end
    end
  end

  assign ovf    = |acc_r[PROD_W-1:DATA_W-1+FRAC_BITS];
  assign done   = busy_r && phase_r == PH_LAST;
  assign result = fx_sat(ovf, neg_r, acc_r[DATA_W-1+FRAC_BITS:FRAC_BITS]);

endmodule

### rtl/rpn_div.sv
module rpn_div
  import rpn_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  val_t a,
  input  val_t b,
  output logic done,
  output val_t result
);

  localparam int DCNT_W = $clog2(QUO_W + 1);

  logic              busy_r;
  logic [DCNT_W-1:0] cnt_r;
  mag_t              rem_r, ub_r;
  logic [QUO_W-1:0]  dvd_r, quo_r;
  logic              neg_r;
  logic [DATA_W:0]   trial, diff;
  logic              ge, stepping, ovf;

  assign stepping = busy_r && cnt_r != DCNT_W'(QUO_W);
  assign trial    = {rem_r, dvd_r[QUO_W-1]};
  assign diff     = trial - {1'b0, ub_r};
  assign ge       = trial >= {1'b0, ub_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (done) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt_r <= '0;
      rem_r <= '0;
      ub_r  <= fx_mag(b);
      dvd_r <= QUO_W'(fx_mag(a)) << FRAC_BITS;
      quo_r <= '0;
      neg_r <= a[DATA_W-1] ^ b[DATA_W-1];
    end else if (stepping) begin
      cnt_r <= cnt_r + DCNT_W'(1);
      dvd_r <= dvd_r << 1;
      rem_r <= ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
      quo_r <= {quo_r[QUO_W-2:0], ge};
    end
  end

  assign ovf    = |quo_r[QUO_W-1:DATA_W-1];
  assign done   = busy_r && cnt_r == DCNT_W'(QUO_W);
  assign result = fx_sat(ovf, neg_r, quo_r[DATA_W-1:0]);

endmodule

### rtl/rpn_expression_evaluator.sv
// Reverse Polish evaluator taking one ASCII character per input word. Tokens
// are split at whitespace; a single digit is pushed, and + - * / pop two
// operands and push the saturated Q23.24 result. The top of stack is held in
// a register and the entries beneath it in a small synchronous memory, so an
// operator needs only one memory read. A digit or separator is taken in the idle
// state, + and - are applied in an execute state, * forms four 24 by 24 partial
// products in turn and / forms one quotient bit per cycle over 72 bits. The
// result word of an expression is loaded into an output register once any
// earlier result is taken, and held while the next expression is taken in.
module rpn_expression_evaluator
  import rpn_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    in_char_code,
  input  logic          in_end_of_expression,
  output logic          out_valid,
  input  logic          out_ready,
  output val_t          out_value,
  output logic [2:0]    out_status
);

  state_t                state_r, state_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [7:0]            tok_char_r, tok_char_nxt;
  logic [TOK_LEN_W-1:0]  tok_len_r, tok_len_nxt;
  status_t               err_r, err_nxt;
  val_t                  tos_r, tos_nxt;
  op_t                   op_r, op_nxt;
  logic                  last_r, last_nxt;
  logic                  out_valid_r, out_valid_nxt;
  val_t                  out_value_r, out_value_nxt;
  status_t               out_status_r, out_status_nxt;

  logic                  accept, is_sep, ending, tok_live, tok_long, tok_digit, tok_op;
  logic                  enough, go_op, can_out;
  logic [7:0]            upd_char, end_char;
  logic [TOK_LEN_W-1:0]  upd_len, end_len;
  op_t                   tok_opc;
  state_t                after_op;

  logic                  ram_wr_en;
  val_t                  ram_rd_data;
  logic                  mul_start, mul_done, div_start, div_done;
  val_t                  mul_res, div_res;
  logic [DATA_W:0]       sum;
  val_t                  sum_sat;

  assign in_ready = state_r == S_IDLE;
  assign accept   = in_valid && in_ready;
  assign can_out  = !out_valid_r || out_ready;
  assign after_op = last_r ? S_FIN : S_IDLE;

  always_comb begin
    is_sep   = in_char_code == CH_SPACE || (in_char_code >= CH_TAB && in_char_code <= CH_CR);
    upd_char = tok_char_r;
    upd_len  = tok_len_r;
    if (err_r == ST_OK) begin
      if (tok_len_r == '0) begin
        upd_char = in_char_code;
      end
      if (tok_len_r != TOK_LEN_W'(2)) begin
        upd_len = tok_len_r + TOK_LEN_W'(1);
      end
    end
    end_char  = is_sep ? tok_char_r : upd_char;
    end_len   = is_sep ? tok_len_r : upd_len;
    ending    = is_sep || in_end_of_expression;
    tok_live  = ending && end_len != '0 && err_r == ST_OK;
    tok_long  = end_len != TOK_LEN_W'(1);
    tok_digit = end_char >= CH_0 && end_char <= CH_9;
    tok_op    = 1'b1;
    tok_opc   = OP_ADD;
    unique case (end_char)
      CH_PLUS:  tok_opc = OP_ADD;
      CH_MINUS: tok_opc = OP_SUB;
      CH_STAR:  tok_opc = OP_MUL;
      CH_SLASH: tok_opc = OP_DIV;
      default:  tok_op  = 1'b0;
    endcase
    enough = count_r >= CNT_W'(2);
    go_op  = tok_live && !tok_long && tok_op && enough;
  end

  always_comb begin
    sum = {ram_rd_data[DATA_W-1], ram_rd_data} + (op_r == OP_SUB ?
          -{tos_r[DATA_W-1], tos_r} : {tos_r[DATA_W-1], tos_r});
    if (sum[DATA_W] != sum[DATA_W-1]) begin
      sum_sat = sum[DATA_W] ? VAL_MIN : VAL_MAX;
    end else begin
      sum_sat = val_t'(sum[DATA_W-1:0]);
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (go_op) begin
            state_nxt = S_EXEC;
          end else if (in_end_of_expression) begin
            state_nxt = S_FIN;
          end
        end
      end
      S_EXEC: begin
        case (op_r)
          OP_MUL:  state_nxt = S_MUL;
          OP_DIV:  state_nxt = (tos_r == '0) ? after_op : S_DIV;
          default: state_nxt = after_op;
        endcase
      end
      S_MUL: begin
        if (mul_done) begin
          state_nxt = after_op;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = after_op;
        end
      end
      S_FIN: begin
        if (can_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    count_nxt      = count_r;
    tok_char_nxt   = tok_char_r;
    tok_len_nxt    = tok_len_r;
    err_nxt        = err_r;
    tos_nxt        = tos_r;
    op_nxt         = op_r;
    last_nxt       = last_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    ram_wr_en      = 1'b0;
    mul_start      = 1'b0;
    div_start      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          last_nxt = in_end_of_expression;
          op_nxt   = tok_opc;
          if (ending) begin
            tok_char_nxt = '0;
            tok_len_nxt  = '0;
          end else begin
            tok_char_nxt = upd_char;
            tok_len_nxt  = upd_len;
          end
          if (tok_live) begin
            if (tok_long) begin
              err_nxt = ST_INVALID;
            end else if (tok_digit) begin
              if (count_r == CNT_W'(STACK_DEPTH)) begin
                err_nxt = ST_OVERFLOW;
              end else begin
                ram_wr_en = count_r != '0;
                tos_nxt   = val_t'(DATA_W'(end_char - CH_0) << FRAC_BITS);
                count_nxt = count_r + CNT_W'(1);
              end
            end else if (tok_op) begin
              if (!enough) begin
                err_nxt = ST_FEW;
              end
            end else begin
              err_nxt = ST_INVALID;
            end
          end
        end
      end
      S_EXEC: begin
        case (op_r)
          OP_MUL: mul_start = 1'b1;
          OP_DIV: begin
            if (tos_r == '0) begin
              err_nxt = ST_DIV0;
            end else begin
              div_start = 1'b1;
            end
          end
          default: begin
            tos_nxt   = sum_sat;
            count_nxt = count_r - CNT_W'(1);
          end
        endcase
      end
      S_MUL: begin
        if (mul_done) begin
          tos_nxt   = mul_res;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      S_DIV: begin
        if (div_done) begin
          tos_nxt   = div_res;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      S_FIN: begin
        if (can_out) begin
          out_valid_nxt = 1'b1;
          if (err_r != ST_OK) begin
            out_status_nxt = err_r;
            out_value_nxt  = '0;
          end else if (count_r != CNT_W'(1)) begin
            out_status_nxt = ST_DEPTH;
            out_value_nxt  = '0;
          end else begin
            out_status_nxt = ST_OK;
            out_value_nxt  = tos_r;
          end
          count_nxt    = '0;
          err_nxt      = ST_OK;
          tok_char_nxt = '0;
          tok_len_nxt  = '0;
        end
      end
      default: begin
        count_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      tok_char_r  <= '0;
      tok_len_r   <= '0;
      err_r       <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      tok_char_r  <= tok_char_nxt;
      tok_len_r   <= tok_len_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tos_r        <= tos_nxt;
    op_r         <= op_nxt;
    last_r       <= last_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

  rpn_stack_ram u_stack (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ADDR_W'(count_r - CNT_W'(1))),
    .wr_data (tos_r),
    .rd_addr (ADDR_W'(count_r - CNT_W'(2))),
    .rd_data (ram_rd_data)
  );

  rpn_mul u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .a      (ram_rd_data),
    .b      (tos_r),
    .done   (mul_done),
    .result (mul_res)
  );

  rpn_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .a      (ram_rd_data),
    .b      (tos_r),
    .done   (div_done),
    .result (div_res)
  );

  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;

endmodule

### tb/rpn_checker.sv
`timescale 1ns / 1ps

module rpn_checker
  import rpn_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_char_code,
  input  logic       in_end_of_expression,
  input  logic       out_valid,
  input  logic       out_ready,
  input  val_t       out_value,
  input  logic [2:0] out_status,
  output int         fail_count,
  output int         results_due
);

  val_t       operands [STACK_DEPTH];
  int         depth;
  logic [7:0] tok_char;
  int         tok_len;
  status_t    err;
  val_t       want_value_q[$];
  status_t    want_status_q[$];

  task automatic log_mismatch(input string what, input logic [63:0] got,
                              input logic [63:0] want);
    $display("%0t ns: %s mismatch, got %0h, expected %0h", $time, what, got, want);
    fail_count++;
  endtask

  function automatic logic [DATA_W-1:0] abs_of(input val_t v);
    logic [DATA_W-1:0] m;
    m = v;
    if (v[DATA_W-1]) begin
      m = ~m + 1'b1;
    end
    return m;
  endfunction

  function automatic val_t clamp_q(input logic signed [99:0] x);
    if (x > VAL_MAX) begin
      return VAL_MAX;
    end
    if (x < VAL_MIN) begin
      return VAL_MIN;
    end
    return val_t'(x);
  endfunction

  function automatic val_t fixed_mul(input val_t a, input val_t b);
    logic [PROD_W-1:0]  prod;
    logic signed [99:0] wide;
    prod = {{DATA_W{1'b0}}, abs_of(a)} * {{DATA_W{1'b0}}, abs_of(b)};
    wide = $signed({4'd0, prod >> FRAC_BITS});
    if (a[DATA_W-1] ^ b[DATA_W-1]) begin
      wide = -wide;
    end
    return clamp_q(wide);
  endfunction

  function automatic val_t fixed_div(input val_t a, input val_t b);
    logic [QUO_W-1:0]   num;
    logic [QUO_W-1:0]   quot;
    logic signed [99:0] wide;
    num  = QUO_W'(abs_of(a)) << FRAC_BITS;
    quot = num / QUO_W'(abs_of(b));
    wide = $signed({28'd0, quot});
    if (a[DATA_W-1] ^ b[DATA_W-1]) begin
      wide = -wide;
    end
    return clamp_q(wide);
  endfunction

  task automatic note_error(input status_t code);
    if (err == ST_OK) begin
      err = code;
    end
  endtask

  task automatic push_operand(input val_t v);
    if (depth >= STACK_DEPTH) begin
      note_error(ST_OVERFLOW);
      return;
    end
    operands[depth] = v;
    depth++;
  endtask

  task automatic close_token();
    logic [7:0]         c;
    int                 n;
    val_t               a;
    val_t               b;
    val_t               r;
    logic signed [99:0] wa;
    logic signed [99:0] wb;
    c        = tok_char;
    n        = tok_len;
    tok_char = '0;
    tok_len  = 0;
    if (n == 0 || err != ST_OK) begin
      return;
    end
    if (n != 1) begin
      note_error(ST_INVALID);
      return;
    end
    if (c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH) begin
      if (depth < 2) begin
        note_error(ST_FEW);
        return;
      end
      b = operands[depth-1];
      a = operands[depth-2];
      if (c == CH_SLASH && b == '0) begin
        note_error(ST_DIV0);
        return;
      end
      wa = a;
      wb = b;
      case (c)
        CH_PLUS:  r = clamp_q(wa + wb);
        CH_MINUS: r = clamp_q(wa - wb);
        CH_STAR:  r = fixed_mul(a, b);
        default:  r = fixed_div(a, b);
      endcase
      depth -= 2;
      push_operand(r);
    end else if (c >= CH_0 && c <= CH_9) begin
      push_operand(val_t'(c - CH_0) <<< FRAC_BITS);
    end else begin
      note_error(ST_INVALID);
    end
  endtask

  task automatic take_word(input logic [7:0] ch, input logic last);
    val_t    v;
    status_t st;
    if (ch == CH_SPACE || (ch >= CH_TAB && ch <= CH_CR)) begin
      close_token();
    end else if (err == ST_OK) begin
      if (tok_len == 0) begin
        tok_char = ch;
      end
      if (tok_len < 2) begin
        tok_len++;
      end
    end
    if (!last) begin
      return;
    end
    // The word that ends an expression also ends its last token.
    close_token();
    st = err;
    v  = '0;
    if (st == ST_OK) begin
      if (depth != 1) begin
        st = ST_DEPTH;
      end else begin
        v = operands[0];
      end
    end
    want_value_q.push_back(v);
    want_status_q.push_back(st);
    depth    = 0;
    tok_char = '0;
    tok_len  = 0;
    err      = ST_OK;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      depth    = 0;
      tok_char = '0;
      tok_len  = 0;
      err      = ST_OK;
      want_value_q.delete();
      want_status_q.delete();
    end else begin
      if (in_valid && in_ready) begin
        take_word(in_char_code, in_end_of_expression);
      end
      if (out_valid && out_ready) begin
        if (want_status_q.size() == 0) begin
          log_mismatch("unexpected result word", 64'(out_status), 64'(0));
        end else begin
          if (out_value !== want_value_q[0]) begin
            log_mismatch("value", 64'(out_value), 64'(want_value_q[0]));
          end
          if (out_status !== want_status_q[0]) begin
            log_mismatch("status", 64'(out_status), 64'(want_status_q[0]));
          end
          void'(want_value_q.pop_front());
          void'(want_status_q.pop_front());
        end
      end
    end
    results_due = want_status_q.size();
  end

endmodule

### tb/tb_rpn_expression_evaluator.sv
`timescale 1ns / 1ps

module tb_rpn_expression_evaluator
  import rpn_pkg::*;
();

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int HOLD_CYCLES  = 400;
  localparam int RANDOM_ITEMS = 1600;

  logic       clk                  = 1'b0;
  logic       rst_n                = 1'b0;
  logic       in_valid             = 1'b0;
  logic       in_ready;
  logic [7:0] in_char_code         = '0;
  logic       in_end_of_expression = 1'b0;
  logic       out_valid;
  logic       out_ready            = 1'b0;
  val_t       out_value;
  logic [2:0] out_status;

  int         fail_count;
  int         results_due;
  int         items_sent  = 0;
  int         cycle_count = 0;
  bit         idle_on     = 1'b1;
  bit         hold_req    = 1'b0;
  bit         hold_done   = 1'b0;
  logic [7:0] expr_q[$];

  rpn_expression_evaluator uut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_char_code         (in_char_code),
    .in_end_of_expression (in_end_of_expression),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_value            (out_value),
    .out_status           (out_status)
  );

  rpn_checker checker_i (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_char_code         (in_char_code),
    .in_end_of_expression (in_end_of_expression),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_value            (out_value),
    .out_status           (out_status),
    .fail_count           (fail_count),
    .results_due          (results_due)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end
      out_ready <= !(idle_on && $urandom_range(0, 99) < 13);
    end
  end

  function automatic logic [7:0] pick_sep();
    if ($urandom_range(0, 2) == 0) begin
      return 8'(CH_TAB + $urandom_range(0, 4));
    end
    return CH_SPACE;
  endfunction

  function automatic logic [7:0] pick_digit();
    return 8'(CH_0 + $urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] pick_op();
    case ($urandom_range(0, 9))
      0, 1, 2: return CH_PLUS;
      3, 4, 5: return CH_MINUS;
      6, 7, 8: return CH_STAR;
      default: return CH_SLASH;
    endcase
  endfunction

  task automatic add_token(input logic [7:0] c);
    if (expr_q.size() != 0 || $urandom_range(0, 9) == 0) begin
      expr_q.push_back(pick_sep());
      if ($urandom_range(0, 5) == 0) begin
        expr_q.push_back(pick_sep());
      end
    end
    expr_q.push_back(c);
  endtask

  task automatic send_expr();
    int i;
    for (i = 0; i < expr_q.size(); i++) begin
      @(negedge clk);
      while (idle_on && $urandom_range(0, 99) < 13) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
      in_valid             <= 1'b1;
      in_char_code         <= expr_q[i];
      in_end_of_expression <= (i == expr_q.size() - 1);
      do @(posedge clk); while (!in_ready);
      items_sent++;
    end
    expr_q.delete();
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) begin
      expr_q.push_back(s[i]);
    end
    send_expr();
  endtask

  task automatic wait_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (results_due != 0) @(negedge clk);
  endtask

  task automatic build_formula(input int pushes);
    int depth;
    int left;
    depth = 0;
    left  = pushes;
    while (left > 0 || depth > 1) begin
      if (left > 0 && (depth < 2 || $urandom_range(0, 1) == 0)) begin
        add_token(pick_digit());
        depth++;
        left--;
      end else begin
        add_token(pick_op());
        depth--;
      end
    end
  endtask

  task automatic build_deep(input int pushes);
    repeat (pushes) add_token(pick_digit());
    repeat (pushes - 1) add_token(pick_op());
  endtask

  task automatic build_growth();
    if ($urandom_range(0, 1) == 0) begin
      add_token(CH_0);
      add_token(CH_9);
      add_token(CH_MINUS);
    end else begin
      add_token(CH_9);
    end
    repeat ($urandom_range(3, 12)) begin
      add_token(8'(CH_0 + $urandom_range(5, 9)));
      add_token(CH_STAR);
    end
    if ($urandom_range(0, 1) == 0) begin
      add_token(8'(CH_0 + $urandom_range(1, 3)));
      add_token(CH_9);
      add_token(CH_SLASH);
      add_token(CH_SLASH);
    end
  endtask

  task automatic build_broken();
    case ($urandom_range(0, 4))
      0: begin
        add_token(pick_op());
        build_formula($urandom_range(1, 5));
      end
      1: begin
        build_formula($urandom_range(1, 5));
        add_token(pick_digit());
      end
      2: begin
        build_formula($urandom_range(1, 5));
        expr_q.push_back($urandom_range(0, 1) ? pick_digit() : pick_op());
        add_token(pick_op());
      end
      3: begin
        build_formula($urandom_range(1, 4));
        add_token(8'($urandom_range(0, 255)));
        build_formula($urandom_range(1, 3));
      end
      default: begin
        repeat ($urandom_range(1, 10)) begin
          case ($urandom_range(0, 3))
            0, 1:    expr_q.push_back(8'($urandom_range(0, 255)));
            2:       expr_q.push_back(pick_digit());
            default: expr_q.push_back($urandom_range(0, 1) ? pick_sep() : pick_op());
          endcase
        end
      end
    endcase
  endtask

  task automatic send_random_expr();
    int k;
    k = $urandom_range(0, 99);
    if (k < 55) begin
      build_formula($urandom_range(1, 8));
    end else if (k < 65) begin
      build_growth();
    end else if (k < 72) begin
      build_deep($urandom_range(14, 18));
    end else begin
      build_broken();
    end
    if ($urandom_range(0, 4) == 0) begin
      expr_q.push_back(pick_sep());
    end
    send_expr();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_text("9 3\t*");
    send_text("8 0 /");
    send_text("5 6 +");
    send_text("7 2\n-");
    send_text("-");
    send_text("12");
    expr_q.push_back(8'h00);
    expr_q.push_back(8'hFF);
    send_expr();
    expr_q.push_back(8'hFF);
    send_expr();
    send_text(" ");
    send_text("1 2");
    wait_results();

    while (items_sent < 500) send_random_expr();

    hold_req = 1'b1;
    repeat (6) begin
      build_formula($urandom_range(1, 3));
      send_expr();
    end
    wait_results();

    idle_on = 1'b0;
    while (items_sent < 900) send_random_expr();
    idle_on = 1'b1;
    while (items_sent < RANDOM_ITEMS) send_random_expr();

    wait_results();
    repeat (200) @(negedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
